[rtl/gfd_pkg.sv]
// ----------------------------------------------------------------------------
// gfd_pkg
// shared types and constants of the galvo flat-to-device unit
// ----------------------------------------------------------------------------
package gfd_pkg;

  localparam int unsigned CoordW  = 21;
  localparam int unsigned TScaleW = 20;
  localparam int unsigned GainW   = 24;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 24;
  localparam int unsigned CodeW   = 16;
  localparam int unsigned AngW    = 22;
  localparam int unsigned TgtW    = 30;
  localparam int unsigned CosW    = 17;
  localparam int unsigned FracW   = 20;
  localparam int unsigned MulAW   = 42;
  localparam int unsigned MulBW   = 25;
  localparam int unsigned ProdW   = MulAW + MulBW;

  localparam logic signed [AngW-1:0]  HalfPiQ20  = 22'sd1647099;
  localparam logic [29:0]             TwoOverPi  = 30'd683565276;
  localparam logic [63:0]             HalfPiQ30  = 64'd1686629713;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_Y_TSCALE = 2'd0,
    CFG_X_TSCALE = 2'd1,
    CFG_X_GAIN   = 2'd2,
    CFG_Y_GAIN   = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_UY,
    ST_UY_W,
    ST_MID,
    ST_C1,
    ST_C2,
    ST_C3,
    ST_C4,
    ST_C5,
    ST_CMP_M,
    ST_CMP,
    ST_UX1,
    ST_UX2,
    ST_UX3,
    ST_GX,
    ST_GY,
    ST_GD,
    ST_OUT
  } state_e;

endpackage

[rtl/galvo_flat_to_device_unit.sv]
// ----------------------------------------------------------------------------
// galvo_flat_to_device_unit
// flat-plane point to galvo dac codes with scanner distortion correction
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)            | tuser
// s_axis  | in  | flat_x[20:0] flat_y[41:21]    | blank
// m_axis  | out | dev_x[15:0] dev_y[31:16]      | saturated
// cfg     | in  | we, idx (0..3), data[23:0]    | -
//
// a point is solved by one bisection per axis, and every step of it uses the
// one shared multiplier; the input reopens in the cycle after the result is
// loaded. a blanked point skips the bisection and goes straight to the
// output stage. a finished point waits while the output register
// still holds an untaken result, so the input stalls behind it.
// reset is asynchronous; it clears control state and loads the config registers with their defaults.
module galvo_flat_to_device_unit
  import gfd_pkg::*;
#(
  parameter int unsigned BISECT_STEPS    = 22,
  parameter int unsigned COS_TABLE_DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [47:0]       s_axis_tdata,   // flat_x, flat_y, zero fill
  input  logic              s_axis_tuser,   // blank
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // dev_x, dev_y
  output logic              m_axis_tuser,   // saturated
  input  logic              cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]   cfg_data_i
);

  localparam int unsigned IdxW = $clog2(COS_TABLE_DEPTH + 1);
  localparam int unsigned CntW = $clog2(BISECT_STEPS);

  typedef logic [CosW-1:0] cos_rom_t [COS_TABLE_DEPTH+1];

  function automatic logic [63:0] div_term(input logic [63:0] v, input int n);
    logic [63:0] r;
    case (n)
      1: r = v / 2;
      2: r = v / 12;
      3: r = v / 30;
      4: r = v / 56;
      5: r = v / 90;
      6: r = v / 132;
      7: r = v / 182;
      8: r = v / 240;
      9: r = v / 306;
      default: r = v / 380;
    endcase
    return r;
  endfunction

  function automatic cos_rom_t build_rom();
    cos_rom_t        rom;
    logic [63:0]     x;
    logic [63:0]     x2;
    logic [63:0]     term;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
      x    = (HalfPiQ30 * 64'(k)) / COS_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = signed'(term);
      for (int n = 1; n <= 10; n++) begin
        term = div_term((term * x2) >> 30, n);
        if (n % 2 == 1) sum = sum - signed'(term);
        else sum = sum + signed'(term);
      end
      if (sum < 0) sum = 0;
      r = (sum + 64'sd8192) >>> 14;
      if (r > 64'sd65536) r = 64'sd65536;
      rom[k] = r[CosW-1:0];
    end
    return rom;
  endfunction

  localparam cos_rom_t CosRom = build_rom();

  state_e state_q, state_d;

  logic [TScaleW-1:0] ys_q, xs_q;
  logic [GainW-1:0]   xg_q, yg_q;

  logic signed [CoordW-1:0] fx_q, fy_q;
  logic signed [TgtW-1:0]   u_q;
  logic signed [AngW-1:0]   lo_q, hi_q, mid_q, tx_q, ty_q;
  logic [CntW-1:0]          cnt_q;
  logic                     axis_x_q, cos_only_q;
  logic [CosW-1:0]          cy_q, cos_q, rd0_q, rd1_q;
  logic [FracW-1:0]         frac_q;
  logic                     end_q;
  logic signed [CodeW-1:0]  dx_q, dy_q;
  logic                     sat_q;
  logic signed [ProdW-1:0]  p_q;

  logic [CodeW-1:0] out_x_q, out_y_q;
  logic             out_sat_q, out_vld_q;

  logic signed [MulAW-1:0] op_a;
  logic signed [MulBW-1:0] op_b;
  logic                    mul_en;

  logic [AngW-2:0]         amid;
  logic signed [AngW:0]    mid_sum;
  logic signed [ProdW-1:0] mid_sh;
  logic [IdxW-1:0]         idx, addr0, addr1;
  logic                    at_end;
  logic [CosW-1:0]         dcos;
  logic [45:0]             rnd;
  logic [17:0]             rmag;
  logic                    out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_y_q, out_x_q};
  assign m_axis_tuser  = out_sat_q;
  assign out_free      = !out_vld_q || m_axis_tready;

  assign amid    = mid_q[AngW-1] ? (AngW-1)'(-mid_q) : mid_q[AngW-2:0];
  assign mid_sum = AngW'(lo_q) + AngW'(hi_q) + (AngW+1)'(0);
  assign mid_sh  = {{(ProdW-AngW-16){mid_q[AngW-1]}}, mid_q, 16'b0};
  assign idx     = p_q[FracW +: IdxW];
  assign at_end  = (idx >= IdxW'(COS_TABLE_DEPTH));
  assign addr0   = at_end ? IdxW'(COS_TABLE_DEPTH) : idx;
  assign addr1   = at_end ? IdxW'(COS_TABLE_DEPTH) : idx + IdxW'(1);
  assign dcos    = (rd0_q > rd1_q) ? rd0_q - rd1_q : '0;
  assign rnd     = p_q[45:0] + (46'd1 << 27);
  assign rmag    = rnd[45:28];

  always_ff @(posedge clk_i) begin
    rd0_q <= CosRom[addr0];
    rd1_q <= CosRom[addr1];
  end

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    mul_en = 1'b0;
    case (state_q)
      ST_UY: begin
        op_a = MulAW'(fy_q); op_b = MulBW'({1'b0, ys_q}); mul_en = 1'b1;
      end
      ST_C1: begin
        op_a = MulAW'({1'b0, TwoOverPi}); op_b = MulBW'({1'b0, amid}); mul_en = 1'b1;
      end
      ST_C2: begin
        op_a = MulAW'({1'b0, p_q[49:30]});
        op_b = MulBW'(COS_TABLE_DEPTH); mul_en = 1'b1;
      end
      ST_C4: begin
        op_a = MulAW'({1'b0, frac_q}); op_b = MulBW'({1'b0, dcos}); mul_en = 1'b1;
      end
      ST_CMP_M: begin
        op_a = MulAW'(u_q); op_b = MulBW'({1'b0, cos_q}); mul_en = 1'b1;
      end
      ST_UX1: begin
        op_a = MulAW'(fx_q); op_b = MulBW'({1'b0, xs_q}); mul_en = 1'b1;
      end
      ST_UX2: begin
        op_a = p_q[MulAW-1:0]; op_b = MulBW'({1'b0, cy_q}); mul_en = 1'b1;
      end
      ST_GX: begin
        op_a = MulAW'({1'b0, (tx_q[AngW-1] ? (AngW-1)'(-tx_q) : tx_q[AngW-2:0])});
        op_b = MulBW'({1'b0, xg_q}); mul_en = 1'b1;
      end
      ST_GY: begin
        op_a = MulAW'({1'b0, (ty_q[AngW-1] ? (AngW-1)'(-ty_q) : ty_q[AngW-2:0])});
        op_b = MulBW'({1'b0, yg_q}); mul_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) p_q <= op_a * op_b;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (s_axis_tvalid) state_d = s_axis_tuser ? ST_OUT : ST_UY;
      ST_UY:    state_d = ST_UY_W;
      ST_UY_W:  state_d = ST_MID;
      ST_MID:   state_d = ST_C1;
      ST_C1:    state_d = ST_C2;
      ST_C2:    state_d = ST_C3;
      ST_C3:    state_d = ST_C4;
      ST_C4:    state_d = ST_C5;
      ST_C5:    state_d = cos_only_q ? ST_UX1 : ST_CMP_M;
      ST_CMP_M: state_d = ST_CMP;
      ST_CMP: begin
        if (cnt_q == CntW'(BISECT_STEPS - 1)) state_d = axis_x_q ? ST_GX : ST_C1;
        else state_d = ST_MID;
      end
      ST_UX1:   state_d = ST_UX2;
      ST_UX2:   state_d = ST_UX3;
      ST_UX3:   state_d = ST_MID;
      ST_GX:    state_d = ST_GY;
      ST_GY:    state_d = ST_GD;
      ST_GD:    state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ys_q <= TScaleW'(72792);
      xs_q <= TScaleW'(72792);
      xg_q <= GainW'(10680499);
      yg_q <= GainW'(10680499);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_Y_TSCALE: ys_q <= cfg_data_i[TScaleW-1:0];
        CFG_X_TSCALE: xs_q <= cfg_data_i[TScaleW-1:0];
        CFG_X_GAIN:   xg_q <= cfg_data_i;
        CFG_Y_GAIN:   yg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        fx_q  <= s_axis_tdata[CoordW-1:0];
        fy_q  <= s_axis_tdata[2*CoordW-1:CoordW];
        dx_q  <= -16'sd32768;
        dy_q  <= -16'sd32768;
        sat_q <= 1'b0;
      end
      ST_UY_W, ST_UX3: begin
        u_q        <= state_q == ST_UY_W ? p_q[41:12] : p_q[57:28];
        lo_q       <= -HalfPiQ20;
        hi_q       <= HalfPiQ20;
        cnt_q      <= '0;
        axis_x_q   <= (state_q == ST_UX3);
        cos_only_q <= 1'b0;
      end
      ST_MID: mid_q <= mid_sum[AngW:1];
      ST_C3: begin
        frac_q <= p_q[FracW-1:0];
        end_q  <= at_end;
      end
      ST_C5: begin
        if (end_q) cos_q <= rd0_q;
        else cos_q <= rd0_q - p_q[FracW +: CosW];
        if (cos_only_q) cy_q <= end_q ? rd0_q : rd0_q - p_q[FracW +: CosW];
      end
      ST_CMP: begin
        if (mid_sh < p_q) lo_q <= mid_q;
        else hi_q <= mid_q;
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(BISECT_STEPS - 1)) begin
          if (axis_x_q) tx_q <= mid_q;
          else begin
            ty_q       <= mid_q;
            cos_only_q <= 1'b1;
          end
        end
      end
      ST_GY: begin
        if (rmag > 18'd32767) begin
          dx_q  <= tx_q[AngW-1] ? -16'sd32767 : 16'sd32767;
          sat_q <= 1'b1;
        end else begin
          dx_q <= tx_q[AngW-1] ? -signed'(rmag[CodeW-1:0]) : signed'(rmag[CodeW-1:0]);
        end
      end
      ST_GD: begin
        if (ty_q[AngW-1]) begin
          if (rmag > 18'd32768) begin
            dy_q  <= -16'sd32768;
            sat_q <= 1'b1;
          end else begin
            dy_q <= -signed'(rmag[CodeW-1:0]);
          end
        end else if (rmag > 18'd32767) begin
          dy_q  <= 16'sd32767;
          sat_q <= 1'b1;
        end else begin
          dy_q <= signed'(rmag[CodeW-1:0]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      out_x_q   <= dx_q;
      out_y_q   <= dy_q;
      out_sat_q <= sat_q;
    end
  end

endmodule

[rtl/gfd_checker.sv]
// ----------------------------------------------------------------------------
// gfd_checker
// port-level checks of the galvo flat-to-device unit
// ----------------------------------------------------------------------------
module gfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one point in flight: no input right after a transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // x code of -32768 only ever comes from the blank marker
  a_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[15:0] == 16'h8000 |->
      m_axis_tdata[31:16] == 16'h8000 && !m_axis_tuser)
    else $error("bad blank marker");

endmodule

bind galvo_flat_to_device_unit gfd_checker u_gfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[dv/gfd_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gfd_tb_checker
// watches the point, code and config channels of the galvo unit, computes the
// expected dac codes for every accepted point and compares them in order
// ----------------------------------------------------------------------------
module gfd_tb_checker
  import gfd_pkg::*;
#(
  parameter int unsigned BISECT_STEPS    = 22,
  parameter int unsigned COS_TABLE_DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [47:0]        s_axis_tdata,
  input  logic               s_axis_tuser,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [31:0]        m_axis_tdata,
  input  logic               m_axis_tuser,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output int                 n_pending_o,
  output int                 n_errors_o
);

  typedef struct packed {
    logic [CodeW-1:0] dev_x;
    logic [CodeW-1:0] dev_y;
    logic             saturated;
  } dev_codes_t;

  longint unsigned cos_rom [0:COS_TABLE_DEPTH];
  longint          y_tscale, x_tscale, x_gain, y_gain;
  dev_codes_t      codes_q [$];

  initial begin
    longint unsigned x, x2, term;
    longint          sum, r;
    for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
      x    = (HalfPiQ30 * longint'(k)) / COS_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = longint'(term);
      for (int n = 1; n <= 10; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      r = (sum + (1 << 13)) >>> 14;
      if (r > 65536) r = 65536;
      cos_rom[k] = r;
    end
  end

  function automatic longint cos_q16(longint t);
    longint unsigned a, scaled, pos, idx, frac, c0, c1, d;
    a      = (t < 0) ? -t : t;
    scaled = (a * longint'(TwoOverPi)) >> 30;
    pos    = scaled * COS_TABLE_DEPTH;
    idx    = pos >> FracW;
    frac   = pos & 64'hFFFFF;
    if (idx >= COS_TABLE_DEPTH) return cos_rom[COS_TABLE_DEPTH];
    c0 = cos_rom[idx];
    c1 = cos_rom[idx + 1];
    d  = (c0 > c1) ? c0 - c1 : 0;
    return longint'(c0 - ((d * frac) >> FracW));
  endfunction

  function automatic longint bisect_angle(longint u);
    longint lo, hi, mid;
    lo  = -longint'(HalfPiQ20);
    hi  = longint'(HalfPiQ20);
    mid = 0;
    for (int i = 0; i < BISECT_STEPS; i++) begin
      mid = (lo + hi) >>> 1;
      if (mid * 65536 < u * cos_q16(mid)) lo = mid;
      else hi = mid;
    end
    return mid;
  endfunction

  function automatic longint angle_to_code(longint t, longint gain);
    longint unsigned m;
    longint          r;
    m = ((t < 0) ? -t : t) * gain;
    r = longint'((m + (64'd1 << 27)) >> 28);
    return (t < 0) ? -r : r;
  endfunction

  function automatic dev_codes_t map_point(logic signed [CoordW-1:0] fx,
                                           logic signed [CoordW-1:0] fy,
                                           logic blank);
    dev_codes_t c;
    longint     uy, ux, ty, tx, cy, dx, dy;
    c.saturated = 1'b0;
    if (blank) begin
      c.dev_x = 16'h8000;
      c.dev_y = 16'h8000;
      return c;
    end
    uy = (longint'(fy) * y_tscale) >>> 12;
    ty = bisect_angle(uy);
    cy = cos_q16(ty);
    ux = (longint'(fx) * x_tscale * cy) >>> 28;
    tx = bisect_angle(ux);
    dx = angle_to_code(tx, x_gain);
    dy = angle_to_code(ty, y_gain);
    if (dx < -32767) begin dx = -32767; c.saturated = 1'b1; end
    if (dx > 32767) begin dx = 32767; c.saturated = 1'b1; end
    if (dy < -32768) begin dy = -32768; c.saturated = 1'b1; end
    if (dy > 32767) begin dy = 32767; c.saturated = 1'b1; end
    c.dev_x = dx[CodeW-1:0];
    c.dev_y = dy[CodeW-1:0];
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dev_codes_t exp_c, got_c;
    if (!rst_ni) begin
      y_tscale = 72792;
      x_tscale = 72792;
      x_gain   = 10680499;
      y_gain   = 10680499;
      codes_q.delete();
      n_errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_Y_TSCALE: y_tscale = cfg_data_i[TScaleW-1:0];
          CFG_X_TSCALE: x_tscale = cfg_data_i[TScaleW-1:0];
          CFG_X_GAIN:   x_gain   = cfg_data_i[GainW-1:0];
          CFG_Y_GAIN:   y_gain   = cfg_data_i[GainW-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_c = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser};
        if (codes_q.size() == 0) begin
          $display("%0t: unexpected code transfer %h", $time, got_c);
          n_errors_o++;
        end else begin
          exp_c = codes_q.pop_front();
          if (got_c.dev_x !== exp_c.dev_x) begin
            $display("%0t: dev_x exp %h got %h", $time, exp_c.dev_x, got_c.dev_x);
            n_errors_o++;
          end
          if (got_c.dev_y !== exp_c.dev_y) begin
            $display("%0t: dev_y exp %h got %h", $time, exp_c.dev_y, got_c.dev_y);
            n_errors_o++;
          end
          if (got_c.saturated !== exp_c.saturated) begin
            $display("%0t: saturated exp %b got %b", $time, exp_c.saturated,
                     got_c.saturated);
            n_errors_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        codes_q.insert(codes_q.size(), map_point(s_axis_tdata[20:0],
                                                 s_axis_tdata[41:21],
                                                 s_axis_tuser));
    end
    n_pending_o = codes_q.size();
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives points and register writes into the galvo flat-to-device unit under
// several register settings and stall patterns; the checker does the compare
// ----------------------------------------------------------------------------
module tb_top
  import gfd_pkg::*;
();

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [47:0]        s_axis_tdata = '0;
  logic               s_axis_tuser = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [31:0]        m_axis_tdata;
  logic               m_axis_tuser;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]    cfg_data_i = '0;
  int                 n_pending, n_errors;
  int                 tx_idle = 32, rx_idle = 52;
  int                 hold_left = 0;
  bit                 hold_req = 0, hold_taken = 0;

  always #10 clk_i = ~clk_i;

  galvo_flat_to_device_unit u_top (.*);

  gfd_tb_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .n_pending_o(n_pending), .n_errors_o(n_errors)
  );

  // receiver: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= 2000;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic send_point(logic [CoordW-1:0] fx, logic [CoordW-1:0] fy, logic blank);
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, fy, fx};
    s_axis_tuser  <= blank;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_and_write(logic [TScaleW-1:0] ys, logic [TScaleW-1:0] xs,
                                 logic [GainW-1:0] xg, logic [GainW-1:0] yg);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (n_pending != 0);
    repeat (50) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= CFG_Y_TSCALE; cfg_data_i <= CfgW'(ys); @(posedge clk_i);
    cfg_idx_i <= CFG_X_TSCALE; cfg_data_i <= CfgW'(xs); @(posedge clk_i);
    cfg_idx_i <= CFG_X_GAIN;   cfg_data_i <= xg; @(posedge clk_i);
    cfg_idx_i <= CFG_Y_GAIN;   cfg_data_i <= yg; @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CoordW-1:0] rand_coord();
    case ($urandom_range(3))
      0: return CoordW'($urandom);
      1: return CoordW'(signed'($urandom_range(131072)) - 65536);
      2: return CoordW'(signed'($urandom_range(16384)) - 8192);
      default: return $urandom_range(1) ? 21'h0FFFFF : 21'h100000;
    endcase
  endfunction

  task automatic random_points(int n);
    for (int i = 0; i < n; i++)
      send_point(rand_coord(), rand_coord(), $urandom_range(9) == 0);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // extremes, zero, blank with odd coordinates
    send_point(21'h0, 21'h0, 1'b0);
    send_point(21'h0FFFFF, 21'h0FFFFF, 1'b0);
    send_point(21'h100000, 21'h100000, 1'b0);
    send_point(21'h0FFFFF, 21'h100000, 1'b0);
    send_point(21'h100000, 21'h0FFFFF, 1'b0);
    send_point(21'h010000, 21'h1F0000, 1'b0);
    send_point(21'h1FFFFF, 21'h000001, 1'b0);
    send_point(21'h0FFFFF, 21'h100000, 1'b1);
    send_point(21'h155555, 21'h0AAAAA, 1'b1);
    send_point(21'h004000, 21'h1FC000, 1'b0);
    drain_and_write(20'hFFFFF, 20'hFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_point(21'h000001, 21'h1FFFFF, 1'b0);
    send_point(21'h0FFFFF, 21'h0FFFFF, 1'b0);
    send_point(21'h100000, 21'h100000, 1'b0);
    random_points(60);
    drain_and_write(20'h0, 20'h0, 24'h0, 24'h0);
    send_point(21'h0FFFFF, 21'h100000, 1'b0);
    random_points(40);
    tx_idle = 52; rx_idle = 32;
    drain_and_write(TScaleW'($urandom), TScaleW'($urandom),
                    GainW'($urandom), GainW'($urandom));
    hold_req = 1;
    random_points(80);
    drain_and_write(TScaleW'(72792), TScaleW'(72792),
                    GainW'(10680499), GainW'(10680499));
    random_points(80);
    tx_idle = 0; rx_idle = 0;
    drain_and_write(TScaleW'($urandom_range(20000, 100000)),
                    TScaleW'($urandom_range(20000, 100000)),
                    GainW'($urandom_range(24'hFFFFFF)),
                    GainW'($urandom_range(24'hFFFFFF)));
    random_points(120);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (n_pending != 0);
    repeat (400) @(posedge clk_i);
    if (n_errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #30ms;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
